// File: hw/rtl/brl_pkg.sv
// Shared constants and types for the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package brl_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  localparam int MAX_W    = 12;
  localparam int STRIDE_W = 15;
  localparam int BPP_W    = 3;
  localparam int OFFSET_W = 26;
  localparam int COLOR_W  = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [MAX_W-1:0]    MAX_X_RST  = 12'd1919;
  localparam logic [MAX_W-1:0]    MAX_Y_RST  = 12'd1079;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 15'd7680;
  localparam logic [BPP_W-1:0]    BPP_RST    = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_X  = 2'd0,
    CFG_MAX_Y  = 2'd1,
    CFG_STRIDE = 2'd2,
    CFG_BPP    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic active;
    logic x_major;
    logic dir_x_neg;
    logic dir_y_neg;
  } line_flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/brl_skid.sv
// Two-entry output register with skid stage for the pixel stream.
`timescale 1ns / 1ps
`default_nettype none
module brl_skid #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              room,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;

  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_ready) begin
      // output stalled: park a new word in the skid stage
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/brl_step.sv
// Line setup with clip reject, one Bresenham step, and pixel offset/visibility.
`timescale 1ns / 1ps
`default_nettype none
module brl_step #(
  parameter int CW = brl_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          load,
  input  wire logic                          tick,
  input  wire logic [CW-1:0]                 start_x,
  input  wire logic [CW-1:0]                 start_y,
  input  wire logic [CW-1:0]                 end_x,
  input  wire logic [CW-1:0]                 end_y,
  input  wire logic [brl_pkg::MAX_W-1:0]     max_x,
  input  wire logic [brl_pkg::MAX_W-1:0]     max_y,
  input  wire logic [brl_pkg::STRIDE_W-1:0]  stride,
  input  wire logic [brl_pkg::BPP_W-1:0]     bpp,
  input  wire logic [CW-1:0]                 cur_x,
  input  wire logic [CW-1:0]                 cur_y,
  input  wire logic [CW-1:0]                 span_x,
  input  wire logic [CW-1:0]                 span_y,
  input  wire logic [CW+2:0]                 err,
  input  wire logic [CW:0]                   pts,
  input  wire brl_pkg::line_flags_t          flags,
  output logic [CW-1:0]                      cur_x_nxt,
  output logic [CW-1:0]                      cur_y_nxt,
  output logic [CW-1:0]                      span_x_nxt,
  output logic [CW-1:0]                      span_y_nxt,
  output logic [CW+2:0]                      err_nxt,
  output logic [CW:0]                        pts_nxt,
  output brl_pkg::line_flags_t               flags_nxt,
  output logic                               emit,
  output logic                               pix_visible,
  output logic                               pix_last,
  output logic [brl_pkg::OFFSET_W-1:0]       pix_offset
);

  localparam int CMP_W = ((CW > brl_pkg::MAX_W) ? CW : brl_pkg::MAX_W) + 1;
  localparam int ERR_W = CW + 3;
  localparam int PTS_W = CW + 1;
  localparam int PY_W  = brl_pkg::MAX_W + brl_pkg::STRIDE_W;
  localparam int PX_W  = brl_pkg::MAX_W + brl_pkg::BPP_W;

  // line setup
  logic [CW:0]            dx, dy, dx_abs, dy_abs;
  logic [CW-1:0]          sx_ld, sy_ld, major_ld;
  logic                   xmaj_ld, reject;
  logic signed [CMP_W-1:0] ax, ay, bx, by, mx, my;

  // pixel and step
  logic signed [CMP_W-1:0] cx, cy;
  logic [PY_W-1:0]        prod_y;
  logic [PX_W-1:0]        prod_x;
  logic [PY_W-1:0]        off_sum;
  logic [ERR_W-1:0]       e1, e2;
  logic                   e1_pos, x_step, y_step;
  logic [CW-1:0]          major_cur, minor_cur;

  always_comb begin
    dx     = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    dy     = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    dx_abs = dx[CW] ? (PTS_W'(0) - dx) : dx;
    dy_abs = dy[CW] ? (PTS_W'(0) - dy) : dy;
    sx_ld  = dx_abs[CW-1:0];
    sy_ld  = dy_abs[CW-1:0];
    xmaj_ld  = sx_ld > sy_ld;
    major_ld = xmaj_ld ? sx_ld : sy_ld;

    ax = {{(CMP_W-CW){start_x[CW-1]}}, start_x};
    ay = {{(CMP_W-CW){start_y[CW-1]}}, start_y};
    bx = {{(CMP_W-CW){end_x[CW-1]}}, end_x};
    by = {{(CMP_W-CW){end_y[CW-1]}}, end_y};
    mx = $signed({{(CMP_W-brl_pkg::MAX_W){1'b0}}, max_x});
    my = $signed({{(CMP_W-brl_pkg::MAX_W){1'b0}}, max_y});
    // drop lines lying wholly beyond one screen edge
    reject = (ax[CMP_W-1] && bx[CMP_W-1]) || (ay[CMP_W-1] && by[CMP_W-1]) ||
             (ax > mx && bx > mx) || (ay > my && by > my);
  end

  always_comb begin
    cx = {{(CMP_W-CW){cur_x[CW-1]}}, cur_x};
    cy = {{(CMP_W-CW){cur_y[CW-1]}}, cur_y};
    pix_visible = !cx[CMP_W-1] && !cy[CMP_W-1] && cx <= mx && cy <= my;
    prod_y  = cy[brl_pkg::MAX_W-1:0] * stride;
    prod_x  = cx[brl_pkg::MAX_W-1:0] * bpp;
    off_sum = prod_y + PY_W'(prod_x);
    pix_offset = pix_visible ? off_sum[brl_pkg::OFFSET_W-1:0] : '0;
    pix_last   = (pts[PTS_W-1:1] == '0);
    emit       = tick && flags.active;

    major_cur = flags.x_major ? span_x : span_y;
    minor_cur = flags.x_major ? span_y : span_x;
    e1     = err + {2'b00, minor_cur, 1'b0};
    e1_pos = !e1[ERR_W-1] && (e1 != '0);
    e2     = e1_pos ? (e1 - {2'b00, major_cur, 1'b0}) : e1;
    x_step = flags.x_major || e1_pos;
    y_step = !flags.x_major || e1_pos;
  end

  always_comb begin
    cur_x_nxt  = cur_x;
    cur_y_nxt  = cur_y;
    span_x_nxt = span_x;
    span_y_nxt = span_y;
    err_nxt    = err;
    pts_nxt    = pts;
    flags_nxt  = flags;
    if (load) begin
      cur_x_nxt  = start_x;
      cur_y_nxt  = start_y;
      span_x_nxt = sx_ld;
      span_y_nxt = sy_ld;
      err_nxt    = ERR_W'(0) - {3'b000, major_ld};
      pts_nxt    = {1'b0, major_ld} + PTS_W'(1);
      flags_nxt.active    = !reject;
      flags_nxt.x_major   = xmaj_ld;
      flags_nxt.dir_x_neg = dx[CW] || (dx == '0);
      flags_nxt.dir_y_neg = dy[CW] || (dy == '0);
    end else if (emit) begin
      if (x_step) begin
        cur_x_nxt = flags.dir_x_neg ? (cur_x - CW'(1)) : (cur_x + CW'(1));
      end
      if (y_step) begin
        cur_y_nxt = flags.dir_y_neg ? (cur_y - CW'(1)) : (cur_y + CW'(1));
      end
      err_nxt = e2;
      pts_nxt = pix_last ? '0 : (pts - PTS_W'(1));
      flags_nxt.active = !pix_last;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bresenham_line_rasterizer_unit.sv
// Top level: Bresenham line rasterizer with clip reject and byte offset output.
// An accepted tick's pixel is registered into the output register, or into the skid stage while the output is stalled.
// Throughput: one word per cycle while in_tready is high; the line state steps once per accepted tick.
// in_tready drops only while the skid stage holds a word behind a stalled output.
// Reset (rst_n low, synchronous): no line loaded, output empty, registers to
// max_x 1919, max_y 1079, stride 7680, 4 bytes per pixel.
`timescale 1ns / 1ps
`default_nettype none
module bresenham_line_rasterizer_unit #(
  parameter int COORD_WIDTH = brl_pkg::COORD_WIDTH_DEF,
  localparam int IN_RAW_W   = 4 * COORD_WIDTH + brl_pkg::COLOR_W,
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8,
  localparam int OUT_RAW_W  = 2 * COORD_WIDTH + brl_pkg::COLOR_W + brl_pkg::OFFSET_W,
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // start_x, start_y, end_x, end_y, color (lowest bits first), zero padded
  input  wire logic [IN_DATA_W-1:0]            in_tdata,
  // kind
  input  wire logic                            in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // pixel_x, pixel_y, pixel_color, byte_offset (lowest bits first), zero padded
  output logic [OUT_DATA_W-1:0]                out_tdata,
  // visible
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [brl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [brl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = COORD_WIDTH;

  logic [brl_pkg::MAX_W-1:0]    max_x_r, max_y_r;
  logic [brl_pkg::STRIDE_W-1:0] stride_r;
  logic [brl_pkg::BPP_W-1:0]    bpp_r;

  logic [CW-1:0]  cur_x_r, cur_y_r, span_x_r, span_y_r;
  logic [CW-1:0]  cur_x_nxt, cur_y_nxt, span_x_nxt, span_y_nxt;
  logic [CW+2:0]  err_r, err_nxt;
  logic [CW:0]    pts_r, pts_nxt;
  logic [brl_pkg::COLOR_W-1:0] color_r;
  brl_pkg::line_flags_t flags_r, flags_nxt;

  logic [CW-1:0]               in_sx, in_sy, in_ex, in_ey;
  logic [brl_pkg::COLOR_W-1:0] in_color;
  logic                        in_acc, load, tick, room, emit;
  logic                        pix_visible, pix_last;
  logic [brl_pkg::OFFSET_W-1:0] pix_offset;
  logic [OUT_RAW_W+1:0]        push_data, skid_out;

  assign in_sx    = in_tdata[CW-1:0];
  assign in_sy    = in_tdata[2*CW-1:CW];
  assign in_ex    = in_tdata[3*CW-1:2*CW];
  assign in_ey    = in_tdata[4*CW-1:3*CW];
  assign in_color = in_tdata[IN_RAW_W-1:4*CW];

  assign in_tready = room;
  assign in_acc    = in_tvalid && room;
  assign load      = in_acc && (brl_pkg::item_kind_t'(in_tuser) == brl_pkg::KIND_LOAD);
  assign tick      = in_acc && (brl_pkg::item_kind_t'(in_tuser) == brl_pkg::KIND_TICK);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r  <= brl_pkg::MAX_X_RST;
      max_y_r  <= brl_pkg::MAX_Y_RST;
      stride_r <= brl_pkg::STRIDE_RST;
      bpp_r    <= brl_pkg::BPP_RST;
    end else if (cfg_valid) begin
      unique case (brl_pkg::cfg_reg_t'(cfg_index))
        brl_pkg::CFG_MAX_X:  max_x_r  <= cfg_data[brl_pkg::MAX_W-1:0];
        brl_pkg::CFG_MAX_Y:  max_y_r  <= cfg_data[brl_pkg::MAX_W-1:0];
        brl_pkg::CFG_STRIDE: stride_r <= cfg_data[brl_pkg::STRIDE_W-1:0];
        brl_pkg::CFG_BPP:    bpp_r    <= cfg_data[brl_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  brl_step #(
    .CW(CW)
  ) u_step (
    .load        (load),
    .tick        (tick),
    .start_x     (in_sx),
    .start_y     (in_sy),
    .end_x       (in_ex),
    .end_y       (in_ey),
    .max_x       (max_x_r),
    .max_y       (max_y_r),
    .stride      (stride_r),
    .bpp         (bpp_r),
    .cur_x       (cur_x_r),
    .cur_y       (cur_y_r),
    .span_x      (span_x_r),
    .span_y      (span_y_r),
    .err         (err_r),
    .pts         (pts_r),
    .flags       (flags_r),
    .cur_x_nxt   (cur_x_nxt),
    .cur_y_nxt   (cur_y_nxt),
    .span_x_nxt  (span_x_nxt),
    .span_y_nxt  (span_y_nxt),
    .err_nxt     (err_nxt),
    .pts_nxt     (pts_nxt),
    .flags_nxt   (flags_nxt),
    .emit        (emit),
    .pix_visible (pix_visible),
    .pix_last    (pix_last),
    .pix_offset  (pix_offset)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    span_x_r <= span_x_nxt;
    span_y_r <= span_y_nxt;
    err_r    <= err_nxt;
    pts_r    <= pts_nxt;
    if (load) begin
      color_r <= in_color;
    end
  end

  assign push_data = {pix_last, pix_visible, pix_offset, color_r, cur_y_r, cur_x_r};

  brl_skid #(
    .W(OUT_RAW_W + 2)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (push_data),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (skid_out)
  );

  assign out_tdata = OUT_DATA_W'(skid_out[OUT_RAW_W-1:0]);
  assign out_tuser = skid_out[OUT_RAW_W];
  assign out_tlast = skid_out[OUT_RAW_W+1];

endmodule
`default_nettype wire

// File: verif/bresenham_line_rasterizer_unit_test.sv
// Self-checking stream testbench for the Bresenham line rasterizer unit.
`timescale 1ns / 1ps
module bresenham_line_rasterizer_unit_test;

  localparam int IDLE_LIMIT = 5000;
  localparam int COORD_MIN  = -32768;
  localparam int COORD_MAX  = 32767;

  typedef struct {
    int              x;
    int              y;
    logic [31:0]     color;
    logic [25:0]     offset;
    logic            visible;
    logic            last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic [95:0]                    in_tdata;
  logic                           in_tuser;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [95:0]                    out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [brl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [brl_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow registers and line state of the predictor
  int          clip_max_x  = int'(brl_pkg::MAX_X_RST);
  int          clip_max_y  = int'(brl_pkg::MAX_Y_RST);
  int          row_stride  = int'(brl_pkg::STRIDE_RST);
  int          pixel_bytes = int'(brl_pkg::BPP_RST);
  int          pos_x, pos_y, span_x, span_y, err_acc, points_left;
  bit          step_x_neg, step_y_neg, x_major, line_live;
  logic [31:0] line_rgb;

  pixel_t pending_pixels[$];
  int     error_count;
  int     words_sent;
  int     idle_cycles;
  int     rx_hold_left;
  bit     tx_gaps_on;
  bit     rx_stalls_on;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bresenham_line_rasterizer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int wrap_coord(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return t;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(80, 20);
  endfunction

  // mostly around the clip window, some anywhere, some at the range ends
  function automatic int pick_coord(int lim);
    int                 r;
    logic signed [15:0] raw;
    r   = $urandom_range(99);
    raw = 16'($urandom);
    if (r < 80) return int'($urandom_range(lim + 16)) - 8;
    if (r < 90) return int'(raw);
    if (r < 95) return r[0] ? COORD_MIN : COORD_MAX;
    return lim + int'($urandom_range(40, 1));
  endfunction

  function automatic void predict_line_load(int sx, int sy, int ex, int ey, logic [31:0] col);
    int dx;
    int dy;
    line_live = 1'b0;
    // drop the line when both ends sit past the same edge
    if ((sx < 0 && ex < 0) || (sy < 0 && ey < 0) ||
        (sx > clip_max_x && ex > clip_max_x) || (sy > clip_max_y && ey > clip_max_y))
      return;
    dx          = ex - sx;
    dy          = ey - sy;
    step_x_neg  = !(dx > 0);
    step_y_neg  = !(dy > 0);
    span_x      = (dx < 0) ? -dx : dx;
    span_y      = (dy < 0) ? -dy : dy;
    x_major     = span_x > span_y;
    err_acc     = x_major ? -span_x : -span_y;
    points_left = (x_major ? span_x : span_y) + 1;
    pos_x       = sx;
    pos_y       = sy;
    line_rgb    = col;
    line_live   = 1'b1;
  endfunction

  function automatic void predict_pixel();
    pixel_t px;
    longint addr;
    if (!line_live) return;
    px.x       = pos_x;
    px.y       = pos_y;
    px.color   = line_rgb;
    px.visible = pos_x >= 0 && pos_y >= 0 && pos_x <= clip_max_x && pos_y <= clip_max_y;
    addr       = 0;
    if (px.visible)
      addr = longint'(pos_y) * row_stride + longint'(pos_x) * pixel_bytes;
    px.offset  = addr[25:0];
    px.last    = points_left <= 1;
    pending_pixels.push_back(px);
    if (x_major) begin
      pos_x   = wrap_coord(pos_x + (step_x_neg ? -1 : 1));
      err_acc = err_acc + 2 * span_y;
      if (err_acc > 0) begin
        err_acc = err_acc - 2 * span_x;
        pos_y   = wrap_coord(pos_y + (step_y_neg ? -1 : 1));
      end
    end else begin
      pos_y   = wrap_coord(pos_y + (step_y_neg ? -1 : 1));
      err_acc = err_acc + 2 * span_x;
      if (err_acc > 0) begin
        err_acc = err_acc - 2 * span_y;
        pos_x   = wrap_coord(pos_x + (step_x_neg ? -1 : 1));
      end
    end
    if (points_left <= 1) begin
      points_left = 0;
      line_live   = 1'b0;
    end else begin
      points_left--;
    end
  endfunction

  task automatic send_word(brl_pkg::item_kind_t kind, int sx, int sy, int ex, int ey,
                           logic [31:0] col);
    int gap;
    in_tdata  <= {col, ey[15:0], ex[15:0], sy[15:0], sx[15:0]};
    in_tuser  <= kind;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (kind == brl_pkg::KIND_LOAD)
      predict_line_load(wrap_coord(sx), wrap_coord(sy), wrap_coord(ex), wrap_coord(ey), col);
    else
      predict_pixel();
    gap = (tx_gaps_on && $urandom_range(99) < 30) ? pick_gap() : 0;
    // keep valid high when the next word follows at once
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_word(brl_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_line(int sx, int sy, int ex, int ey, logic [31:0] col, int ticks);
    send_word(brl_pkg::KIND_LOAD, sx, sy, ex, ey, col);
    repeat (ticks) send_tick();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(brl_pkg::cfg_reg_t idx, int value);
    cfg_index <= idx;
    cfg_data  <= value[brl_pkg::CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      brl_pkg::CFG_MAX_X:  clip_max_x  = value & ((1 << brl_pkg::MAX_W) - 1);
      brl_pkg::CFG_MAX_Y:  clip_max_y  = value & ((1 << brl_pkg::MAX_W) - 1);
      brl_pkg::CFG_STRIDE: row_stride  = value & ((1 << brl_pkg::STRIDE_W) - 1);
      brl_pkg::CFG_BPP:    pixel_bytes = value & ((1 << brl_pkg::BPP_W) - 1);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // park the block with a rejected line, drain, then reprogram
  task automatic set_window(int mx, int my, int stride, int bpp);
    send_word(brl_pkg::KIND_LOAD, -1, -1, -1, -1, '0);
    settle();
    write_reg(brl_pkg::CFG_MAX_X, mx);
    write_reg(brl_pkg::CFG_MAX_Y, my);
    write_reg(brl_pkg::CFG_STRIDE, stride);
    write_reg(brl_pkg::CFG_BPP, bpp);
  endtask

  task automatic random_line();
    int sx, sy, ex, ey, span, d, r, ticks;
    r    = $urandom_range(99);
    span = (r < 80) ? $urandom_range(12) : (r < 97) ? $urandom_range(150, 13) : COORD_MAX * 2 + 1;
    sx   = pick_coord(clip_max_x);
    sy   = pick_coord(clip_max_y);
    d    = int'($urandom_range(2 * span)) - span;
    ex   = clamp_coord(sx + d);
    case ($urandom_range(4))
      0: ey = sy;
      1: begin
        ex = sx;
        ey = clamp_coord(sy + d);
      end
      2: ey = clamp_coord(sy + ($urandom_range(1) ? d : -d));
      default: ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
    endcase
    send_word(brl_pkg::KIND_LOAD, sx, sy, ex, ey, $urandom);
    r = $urandom_range(99);
    if (!line_live)
      ticks = $urandom_range(1);
    else if (points_left > 200)
      ticks = $urandom_range(20, 1);
    else if (r < 10)
      ticks = $urandom_range(points_left - 1);
    else if (r < 18)
      ticks = points_left + $urandom_range(2, 1);
    else
      ticks = points_left;
    repeat (ticks) send_tick();
  endtask

  task automatic random_words(int count);
    int first;
    int r;
    first = words_sent;
    while (words_sent - first < count) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_tick();
      end else if (r < 9) begin
        send_line($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(3));
      end else begin
        random_line();
      end
    end
  endtask

  task automatic test_directed_defaults();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_tick();                                          // nothing loaded yet
    send_line(10, 20, 12, 21, 32'hDEADBEEF, 3);
    send_line(100, 100, 99, 103, 32'h00000000, 4);
    send_line(0, 0, 2, 2, 32'hFFFFFFFF, 3);               // equal spans step y
    send_line(5, 5, 5, 5, 32'h12345678, 1);
    // one rejected line per edge, then a tick that must stay silent
    send_word(brl_pkg::KIND_LOAD, -5, 3, -1, 9, 32'h00000001);
    send_word(brl_pkg::KIND_LOAD, 3, -5, 9, -1, 32'h00000002);
    send_word(brl_pkg::KIND_LOAD, clip_max_x + 1, 3, clip_max_x + 80, 9, 32'h00000003);
    send_word(brl_pkg::KIND_LOAD, 3, clip_max_y + 1, 9, clip_max_y + 20, 32'h00000004);
    send_tick();
    send_line(COORD_MIN, 0, COORD_MAX, clip_max_y, 32'hA5A5A5A5, 2);
    send_line(-2, clip_max_y - 1, 1, clip_max_y + 1, 32'h5A5A5A5A, 4);
    settle();
  endtask

  task automatic test_random_defaults();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    random_words(300);
    settle();
  endtask

  task automatic test_zero_window();
    set_window(0, 0, 0, 0);
    send_line(0, 0, 0, 0, $urandom, 1);
    random_words(150);
    settle();
  endtask

  task automatic test_full_window();
    set_window((1 << brl_pkg::MAX_W) - 1, (1 << brl_pkg::MAX_W) - 1,
               (1 << brl_pkg::STRIDE_W) - 1, (1 << brl_pkg::BPP_W) - 1);
    tx_gaps_on = 1'b0;
    send_line(clip_max_x - 5, clip_max_y, clip_max_x, clip_max_y - 2, 32'hCAFEF00D, 6);
    send_line(0, 0, 0, COORD_MIN, 32'h0F0F0F0F, 2);
    tx_gaps_on = 1'b1;
    random_words(250);
    settle();
  endtask

  task automatic test_odd_pixel_sizes();
    set_window($urandom_range(300), $urandom_range(300), $urandom_range(32767), 5);
    random_words(120);
    set_window($urandom_range(4095), $urandom_range(20), $urandom_range(32767), 6);
    random_words(120);
    settle();
  endtask

  task automatic test_random_configs();
    repeat (2) begin
      set_window($urandom_range(1) ? $urandom_range(4095) : $urandom_range(31),
                 $urandom_range(1) ? $urandom_range(4095) : $urandom_range(31),
                 $urandom_range(32767), $urandom_range(7));
      random_words(200);
    end
    settle();
  endtask

  task automatic test_output_backpressure();
    set_window(int'(brl_pkg::MAX_X_RST), int'(brl_pkg::MAX_Y_RST),
               int'(brl_pkg::STRIDE_RST), int'(brl_pkg::BPP_RST));
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_word(brl_pkg::KIND_LOAD, 0, 0, 60, 17, $urandom);
    // receiver holds off while ticks keep coming, so the input must stall
    rx_hold_left = 300;
    repeat (61) send_tick();
    settle();
  endtask

  initial begin : rx_side
    int gap_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_tready <= 1'b0;
        rx_hold_left--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_stalls_on && $urandom_range(99) < 25) gap_left = pick_gap();
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t px;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel word with no pixel expected: tdata 0x%0h", out_tdata);
        error_count++;
      end else begin
        px = pending_pixels.pop_front();
        check_field("pixel_x", px.x[15:0], out_tdata[15:0]);
        check_field("pixel_y", px.y[15:0], out_tdata[31:16]);
        check_field("pixel_color", px.color, out_tdata[63:32]);
        check_field("byte_offset", px.offset, out_tdata[89:64]);
        check_field("tdata_pad", 0, out_tdata[95:90]);
        check_field("visible", px.visible, out_tuser);
        check_field("last", px.last, out_tlast);
      end
    end
  end

  // end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bresenham_line_rasterizer_unit_test failed");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= brl_pkg::KIND_LOAD;
    in_tvalid  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= brl_pkg::CFG_MAX_X;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_defaults();
    test_random_defaults();
    test_zero_window();
    test_full_window();
    test_odd_pixel_sizes();
    test_random_configs();
    test_output_backpressure();
    settle();
    if (error_count == 0 && pending_pixels.size() == 0)
      $display("bresenham_line_rasterizer_unit_test passed");
    else
      $display("bresenham_line_rasterizer_unit_test failed");
    $finish;
  end

endmodule
